FILE: src/midi_file_event_parser_macros.svh
// Assertion macros shared by the parser modules.
`ifndef MIDI_FILE_EVENT_PARSER_MACROS_SVH
`define MIDI_FILE_EVENT_PARSER_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define MFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define MFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/mfp_pkg.sv
`default_nettype none
package mfp_pkg;
  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_CHANNEL = 3'd1,
    KIND_TEMPO   = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_TAG     = 3'd0,
    ERR_HDR_SHORT   = 3'd1,
    ERR_BAD_FORMAT  = 3'd2,
    ERR_UNSUPPORTED = 3'd3,
    ERR_TRUNCATED   = 3'd4,
    ERR_NO_RUNNING  = 3'd5
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] track_index;
    logic [31:0] tick;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [23:0] tempo;
    logic [1:0]  format;
    logic [15:0] track_count;
    logic [15:0] division;
    logic        division_valid;
    err_t        error_code;
  } result_t;

  localparam result_t RESULT_ZERO = '{kind: KIND_HEADER, error_code: ERR_BAD_TAG,
                                      default: '0};
endpackage
`default_nettype wire

FILE: src/mfp_out_queue.sv
`default_nettype none
module mfp_out_queue
  import mfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_one,
  input  wire logic    push_two,
  input  result_t      row_a,
  input  result_t      row_b,
  output logic         space_ok,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_row
);
  `include "midi_file_event_parser_macros.svh"

  // Four-entry circular queue; the parser may push two rows in one cycle.
  result_t     mem_r [4];
  logic [1:0]  rd_r, wr_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_row   = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  // Accepting needs room for two rows whatever comes out this cycle.
  assign space_ok  = (cnt_r <= 3'd2);

  always_comb begin
    cnt_nxt = cnt_r + {2'b00, push_one} + {2'b00, push_two} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push_one) mem_r[wr_r] <= row_a;
    if (push_two) mem_r[wr_r + 2'd1] <= row_b;
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_r + {1'b0, pop};
      wr_r  <= wr_r + {1'b0, push_one} + {1'b0, push_two};
      cnt_r <= cnt_nxt;
    end
  end

  `MFP_ASSERT_IMP(a_no_overflow, clk, rst_n, push_one || push_two, cnt_r <= 3'd2, "queue overflow")
  `MFP_ASSERT_IMP(a_two_needs_one, clk, rst_n, push_two, push_one, "second row without first")
  `MFP_ASSERT_NEXT(a_count_step, clk, rst_n, !push_one && !pop, cnt_r == $past(cnt_r), "count drift")
endmodule
`default_nettype wire

FILE: src/midi_file_event_parser.sv
// Channel  Direction  Handshake               Payload
// in_      input      in_valid / in_ready     in_data_byte, in_final_req
// out_     output     out_valid / out_ready   kind, track, tick, event, header, error
//
// One byte is taken per cycle while in_ready is high; its results are registered
// in a queue. Each byte yields up to two results, which leave one per cycle,
// while out_ready is high, from a four-entry queue, so in_ready drops only while
// that queue holds three or four rows.
// Reset (rst_n low at a clock edge) returns the parser to the header tag.
// After done or an error all further bytes are accepted and dropped.
`default_nettype none
module midi_file_event_parser
  import mfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_final_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [15:0]      out_track_index,
  output logic [31:0]      out_tick,
  output logic [7:0]       out_status_byte,
  output logic [7:0]       out_data_one,
  output logic [7:0]       out_data_two,
  output logic [23:0]      out_tempo,
  output logic [1:0]       out_format,
  output logic [15:0]      out_track_count,
  output logic [15:0]      out_division,
  output logic             out_division_valid,
  output logic [2:0]       out_error_code
);
  `include "midi_file_event_parser_macros.svh"

  typedef enum logic [3:0] {
    P_HTAG, P_HLEN, P_HDR, P_HSKIP, P_TTAG, P_TLEN, P_DELTA, P_STATUS,
    P_DATA1, P_DATA2, P_MTYPE, P_LEN, P_TEMPO, P_BODY, P_STOP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  bc_r, bc_nxt;
  logic [31:0] len_r, len_nxt, chunk_r, chunk_nxt;
  logic [15:0] trk_r, trk_nxt, total_r, total_nxt, div_r, div_nxt;
  logic [31:0] tick_r, tick_nxt, delta_r, delta_nxt;
  logic [7:0]  run_r, run_nxt, evs_r, evs_nxt, fd_r, fd_nxt, mt_r, mt_nxt;
  logic [27:0] skip_r, skip_nxt;
  logic [23:0] tempo_r, tempo_nxt;
  logic        stop_r, stop_nxt;

  logic        take;
  logic        space_ok;
  logic [7:0]  b;
  logic [1:0]  n;
  result_t     row_a, row_b, row, out_row;
  logic [7:0]  tag_exp;
  logic        intrack;

  assign in_ready = space_ok;
  assign take     = in_valid && in_ready;
  assign b        = in_data_byte;

  // Next-state logic; each result row goes into the first free slot of this byte's pair.
  always_comb begin
    logic        ok;
    logic [27:0] nl;
    phase_nxt = phase_r; bc_nxt = bc_r; len_nxt = len_r; chunk_nxt = chunk_r;
    trk_nxt = trk_r; total_nxt = total_r; div_nxt = div_r; tick_nxt = tick_r;
    delta_nxt = delta_r; run_nxt = run_r; evs_nxt = evs_r; fd_nxt = fd_r;
    mt_nxt = mt_r; skip_nxt = skip_r; tempo_nxt = tempo_r; stop_nxt = stop_r;
    row_a = RESULT_ZERO; row_b = RESULT_ZERO; n = 2'd0; intrack = 1'b0;
    row = RESULT_ZERO; ok = 1'b0; nl = '0;
    tag_exp = 8'h4d;

    // Error rows use pre-update track and tick; truncation errors use the new tick,
    // the final-byte one the new track too. Expected tag bytes are chosen first.
    case (bc_r[1:0])
      2'd0: tag_exp = 8'h4d;
      2'd1: tag_exp = 8'h54;
      2'd2: tag_exp = (phase_r == P_HTAG) ? 8'h68 : 8'h72;
      default: tag_exp = (phase_r == P_HTAG) ? 8'h64 : 8'h6b;
    endcase

    if (!stop_r) begin
      case (phase_r)
        P_HTAG, P_TTAG: begin
          if (b != tag_exp) begin
            row = RESULT_ZERO; row.kind = KIND_ERROR; row.error_code = ERR_BAD_TAG;
            row.track_index = trk_r; row.tick = tick_r;
            row_a = row; n = 2'd1; stop_nxt = 1'b1; phase_nxt = P_STOP;
          end else if (bc_r == 3'd3) begin
            phase_nxt = (phase_r == P_HTAG) ? P_HLEN : P_TLEN;
            bc_nxt = '0; len_nxt = '0;
          end else begin
            bc_nxt = bc_r + 3'd1;
          end
        end
        P_HLEN, P_TLEN: begin
          len_nxt = {len_r[23:0], b};
          if (bc_r == 3'd3) begin
            bc_nxt = '0;
            chunk_nxt = len_nxt;
            if (phase_r == P_HLEN) begin
              if (len_nxt < 32'd6) begin
                row = RESULT_ZERO; row.kind = KIND_ERROR; row.error_code = ERR_HDR_SHORT;
                row.track_index = trk_r; row.tick = tick_r;
                row_a = row; n = 2'd1; stop_nxt = 1'b1; phase_nxt = P_STOP;
              end else begin
                phase_nxt = P_HDR;
              end
            end else begin
              tick_nxt = '0; run_nxt = '0;
              phase_nxt = P_DELTA; delta_nxt = '0;
              if (len_nxt == 32'd0) begin
                trk_nxt = trk_r + 16'd1;
                if (trk_nxt == total_r) begin
                  row = RESULT_ZERO; row.kind = KIND_DONE; row.division = div_r;
                  row.division_valid = div_r[15] ? (div_r[14:8] != 0 && div_r[7:0] != 0)
                                                 : (div_r[14:0] != 0);
                  row_a = row; n = 2'd1; stop_nxt = 1'b1; phase_nxt = P_STOP;
                end else begin
                  phase_nxt = P_TTAG;
                end
              end
            end
          end else begin
            bc_nxt = bc_r + 3'd1;
          end
        end
        P_HDR: begin
          chunk_nxt = chunk_r - 32'd1;
          bc_nxt = bc_r + 3'd1;
          case (bc_r)
            3'd0: if (b != 8'd0) begin
              row = RESULT_ZERO; row.kind = KIND_ERROR; row.error_code = ERR_BAD_FORMAT;
              row.track_index = trk_r; row.tick = tick_r;
              row_a = row; n = 2'd1; stop_nxt = 1'b1; phase_nxt = P_STOP;
            end
            3'd1: if (b > 8'd2) begin
              row = RESULT_ZERO; row.kind = KIND_ERROR; row.error_code = ERR_BAD_FORMAT;
              row.track_index = trk_r; row.tick = tick_r;
              row_a = row; n = 2'd1; stop_nxt = 1'b1; phase_nxt = P_STOP;
            end else fd_nxt = b;
            3'd2: total_nxt = {b, 8'd0};
            3'd3: total_nxt = {total_r[15:8], b};
            3'd4: div_nxt = {b, 8'd0};
            default: begin
              div_nxt = {div_r[15:8], b};
              row = RESULT_ZERO; row.kind = KIND_HEADER; row.format = fd_r[1:0];
              row.track_count = total_r; row.division = div_nxt;
              row_a = row; n = 2'd1;
              if (chunk_nxt == 32'd0) begin
                if (total_r == 16'd0) begin
                  row = RESULT_ZERO; row.kind = KIND_DONE; row.division = div_nxt;
                  row.division_valid = div_nxt[15] ?
                    (div_nxt[14:8] != 0 && div_nxt[7:0] != 0) : (div_nxt[14:0] != 0);
                  row_b = row; n = 2'd2; stop_nxt = 1'b1; phase_nxt = P_STOP;
                end else begin
                  phase_nxt = P_TTAG; bc_nxt = '0;
                end
              end else begin
                phase_nxt = P_HSKIP;
              end
            end
          endcase
        end
        P_HSKIP: begin
          chunk_nxt = chunk_r - 32'd1;
          if (chunk_nxt == 32'd0) begin
            if (total_r == 16'd0) begin
              row = RESULT_ZERO; row.kind = KIND_DONE; row.division = div_r;
              row.division_valid = div_r[15] ? (div_r[14:8] != 0 && div_r[7:0] != 0)
                                             : (div_r[14:0] != 0);
              row_a = row; n = 2'd1; stop_nxt = 1'b1; phase_nxt = P_STOP;
            end else begin
              phase_nxt = P_TTAG; bc_nxt = '0;
            end
          end
        end
        P_STOP: ;
        default: begin
          intrack = 1'b1;
          chunk_nxt = chunk_r - 32'd1;
          case (phase_r)
            P_DELTA: begin
              delta_nxt = {delta_r[24:0], 7'd0} + {25'd0, b[6:0]};
              if (b[7]) bc_nxt = 3'd1;
              else begin
                tick_nxt = tick_r + delta_nxt;
                phase_nxt = P_STATUS;
              end
            end
            P_STATUS, P_DATA1: begin
              // A data byte under running status behaves as a first data byte.
              ok = (phase_r == P_DATA1) || !b[7];
              if (phase_r == P_STATUS && !b[7] && run_r == 8'd0) begin
                ok = 1'b0;
                row = RESULT_ZERO; row.kind = KIND_ERROR; row.error_code = ERR_NO_RUNNING;
                row.track_index = trk_r; row.tick = tick_r;
                row_a = row; n = 2'd1; stop_nxt = 1'b1; phase_nxt = P_STOP;
              end else if (phase_r == P_STATUS && b[7]) begin
                evs_nxt = b;
                if (b[7:4] != 4'hf) phase_nxt = P_DATA1;
                else begin
                  case (b[3:0])
                    4'h0, 4'h7: begin mt_nxt = '0; skip_nxt = '0; phase_nxt = P_LEN; end
                    4'hf: phase_nxt = P_MTYPE;
                    4'h2: begin skip_nxt = 28'd2; phase_nxt = P_BODY; end
                    4'h1, 4'h3: begin skip_nxt = 28'd1; phase_nxt = P_BODY; end
                    4'h6, 4'h8, 4'ha, 4'hb, 4'hc, 4'he: begin
                      phase_nxt = P_DELTA; bc_nxt = '0; delta_nxt = '0;
                    end
                    default: begin
                      row = RESULT_ZERO; row.kind = KIND_ERROR;
                      row.error_code = ERR_UNSUPPORTED;
                      row.track_index = trk_r; row.tick = tick_r;
                      row_a = row; n = 2'd1; stop_nxt = 1'b1; phase_nxt = P_STOP;
                    end
                  endcase
                end
              end
              if (ok) begin
                if (phase_r == P_STATUS) evs_nxt = run_r;
                fd_nxt = b;
                if (evs_nxt[7:4] == 4'hc || evs_nxt[7:4] == 4'hd) begin
                  row = RESULT_ZERO; row.kind = KIND_CHANNEL; row.track_index = trk_r;
                  row.tick = tick_r; row.status_byte = evs_nxt; row.data_one = b;
                  row_a = row; n = 2'd1; run_nxt = evs_nxt;
                  phase_nxt = P_DELTA; bc_nxt = '0; delta_nxt = '0;
                end else phase_nxt = P_DATA2;
              end
            end
            P_DATA2: begin
              row = RESULT_ZERO; row.kind = KIND_CHANNEL; row.track_index = trk_r;
              row.tick = tick_r; row.status_byte = evs_r; row.data_one = fd_r;
              row.data_two = b;
              row_a = row; n = 2'd1; run_nxt = evs_r;
              phase_nxt = P_DELTA; bc_nxt = '0; delta_nxt = '0;
            end
            P_MTYPE: begin mt_nxt = b; skip_nxt = '0; phase_nxt = P_LEN; end
            P_LEN: begin
              nl = {skip_r[20:0], b[6:0]};
              skip_nxt = nl;
              if (!b[7]) begin
                if (evs_r == 8'hff && mt_r == 8'h51 && nl >= 28'd3) begin
                  phase_nxt = P_TEMPO; bc_nxt = '0; tempo_nxt = '0;
                end else if (nl == 28'd0) begin
                  phase_nxt = P_DELTA; bc_nxt = '0; delta_nxt = '0;
                end else phase_nxt = P_BODY;
              end
            end
            P_TEMPO: begin
              tempo_nxt = {tempo_r[15:0], b};
              skip_nxt = skip_r - 28'd1;
              bc_nxt = bc_r + 3'd1;
              if (bc_r == 3'd2) begin
                row = RESULT_ZERO; row.kind = KIND_TEMPO; row.track_index = trk_r;
                row.tick = tick_r; row.status_byte = 8'hff; row.data_one = 8'h51;
                row.tempo = tempo_nxt;
                row_a = row; n = 2'd1;
                if (skip_nxt == 28'd0) begin
                  phase_nxt = P_DELTA; bc_nxt = '0; delta_nxt = '0;
                end else phase_nxt = P_BODY;
              end
            end
            default: begin
              skip_nxt = skip_r - 28'd1;
              if (skip_nxt == 28'd0) begin
                phase_nxt = P_DELTA; bc_nxt = '0; delta_nxt = '0;
              end
            end
          endcase
        end
      endcase

      // End of track by length: clean only at an event boundary.
      if (intrack && !stop_nxt && chunk_nxt == 32'd0) begin
        if (phase_nxt == P_DELTA && bc_nxt == 3'd0) begin
          trk_nxt = trk_r + 16'd1;
          if (trk_nxt == total_r) begin
            row = RESULT_ZERO; row.kind = KIND_DONE; row.division = div_r;
            row.division_valid = div_r[15] ? (div_r[14:8] != 0 && div_r[7:0] != 0)
                                           : (div_r[14:0] != 0);
            stop_nxt = 1'b1; phase_nxt = P_STOP;
          end else begin
            phase_nxt = P_TTAG; bc_nxt = '0;
          end
        end else begin
          row = RESULT_ZERO; row.kind = KIND_ERROR; row.error_code = ERR_TRUNCATED;
          row.track_index = trk_r; row.tick = tick_nxt;
          stop_nxt = 1'b1; phase_nxt = P_STOP;
        end
        if (stop_nxt) begin
          if (n == 2'd0) begin row_a = row; n = 2'd1; end
          else begin row_b = row; n = 2'd2; end
        end
      end

      // The final byte must leave the parse finished.
      if (in_final_req && !stop_nxt) begin
        row = RESULT_ZERO; row.kind = KIND_ERROR; row.error_code = ERR_TRUNCATED;
        row.track_index = trk_nxt; row.tick = tick_nxt;
        stop_nxt = 1'b1; phase_nxt = P_STOP;
        if (n == 2'd0) begin row_a = row; n = 2'd1; end
        else begin row_b = row; n = 2'd2; end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_HTAG; bc_r <= '0; len_r <= '0; chunk_r <= '0; trk_r <= '0;
      total_r <= '0; div_r <= '0; tick_r <= '0; delta_r <= '0; run_r <= '0;
      evs_r <= '0; fd_r <= '0; mt_r <= '0; skip_r <= '0; tempo_r <= '0;
      stop_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt; bc_r <= bc_nxt; len_r <= len_nxt; chunk_r <= chunk_nxt;
      trk_r <= trk_nxt; total_r <= total_nxt; div_r <= div_nxt; tick_r <= tick_nxt;
      delta_r <= delta_nxt; run_r <= run_nxt; evs_r <= evs_nxt; fd_r <= fd_nxt;
      mt_r <= mt_nxt; skip_r <= skip_nxt; tempo_r <= tempo_nxt; stop_r <= stop_nxt;
    end
  end

  mfp_out_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_one(take && n != 2'd0), .push_two(take && n == 2'd2),
    .row_a(row_a), .row_b(row_b), .space_ok(space_ok),
    .out_valid(out_valid), .out_ready(out_ready), .out_row(out_row)
  );

  assign out_kind           = out_row.kind;
  assign out_track_index    = out_row.track_index;
  assign out_tick           = out_row.tick;
  assign out_status_byte    = out_row.status_byte;
  assign out_data_one       = out_row.data_one;
  assign out_data_two       = out_row.data_two;
  assign out_tempo          = out_row.tempo;
  assign out_format         = out_row.format;
  assign out_track_count    = out_row.track_count;
  assign out_division       = out_row.division;
  assign out_division_valid = out_row.division_valid;
  assign out_error_code     = out_row.error_code;

  `MFP_ASSERT_NEXT(a_stop_sticky, clk, rst_n, stop_r, stop_r, "stop flag cleared")
  `MFP_ASSERT_IMP(a_stop_phase, clk, rst_n, stop_r, phase_r == P_STOP, "stopped but parsing")
  `MFP_ASSERT_IMP(a_silent_stop, clk, rst_n, stop_r, n == 2'd0, "result after stop")
endmodule
`default_nettype wire
